[sv/rgb_error_diffusion_dither_defines.svh]
// ----------------------------------------------------------------------------
// RGB error diffusion dither assertion macros
// Shorthand for clocked assertions with the block's clock and reset.
// ----------------------------------------------------------------------------
`ifndef RGB_ERROR_DIFFUSION_DITHER_DEFINES_SVH
`define RGB_ERROR_DIFFUSION_DITHER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RGBD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RGBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/rgbd_pkg.sv]
// ----------------------------------------------------------------------------
// RGB error diffusion dither package
// Shared types, register codes, weights and per-channel arithmetic.
// ----------------------------------------------------------------------------
package rgbd_pkg;

  localparam int MAX_LINE_DEFAULT = 2048;
  localparam int NCH              = 3;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_LEVELS       = 2'd2;

  localparam logic [11:0] IMAGE_WIDTH_RESET  = 12'd640;
  localparam logic [15:0] IMAGE_HEIGHT_RESET = 16'd480;
  localparam logic [7:0]  LEVELS_RESET       = 8'd4;

  localparam int MIN_WIDTH  = 3;
  localparam int MIN_HEIGHT = 2;

  localparam logic [2:0] W_ABOVE_LEFT  = 3'd1;
  localparam logic [2:0] W_ABOVE       = 3'd5;
  localparam logic [2:0] W_ABOVE_RIGHT = 3'd3;
  localparam logic [2:0] W_LEFT        = 3'd7;

  localparam logic [7:0] ROUND_BIAS = 8'd127;

  typedef logic [NCH-1:0][7:0] rgb_t;
  typedef logic [NCH-1:0][8:0] rgb_err_t;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;
  } pixel_out_t;

  typedef struct packed {
    logic [11:0] image_width;
    logic [15:0] image_height;
    logic [7:0]  levels;
    logic [7:0]  step;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic above;
    logic left;
    logic commit;
  } dp_cmd_t;

  function automatic logic signed [7:0] diffuse(logic signed [8:0] e, logic [2:0] w);
    logic signed [12:0] p;
    logic signed [12:0] s;
    p = 13'(e) * $signed({10'd0, w});
    s = p >>> 4;
    return 8'(s);
  endfunction

  function automatic logic [7:0] add_clamp(logic [7:0] v, logic signed [7:0] d);
    logic signed [9:0] s;
    s = $signed({2'b00, v}) + 10'(d);
    if (s < 0) begin
      return 8'd0;
    end else if (s > 10'sd255) begin
      return 8'd255;
    end
    return s[7:0];
  endfunction

  // Quantization step, the integer quotient of full scale by the level count.
  function automatic logic [7:0] step_of(logic [7:0] lv);
    logic [7:0] s;
    s = 8'd0;
    unique case (lv)
      8'd0, 8'd1: s = 8'd255;
      8'd2:       s = 8'd127;
      8'd3:       s = 8'd85;
      8'd4:       s = 8'd63;
      8'd5:       s = 8'd51;
      8'd6:       s = 8'd42;
      8'd7:       s = 8'd36;
      8'd8:       s = 8'd31;
      8'd9:       s = 8'd28;
      8'd10:      s = 8'd25;
      8'd11:      s = 8'd23;
      8'd12:      s = 8'd21;
      8'd13:      s = 8'd19;
      8'd14:      s = 8'd18;
      8'd15:      s = 8'd17;
      default: begin
        for (int k = 1; k < 16; k++) begin
          if (16'(lv) * 16'(k) <= 16'd255) begin
            s = s + 8'd1;
          end
        end
      end
    endcase
    return s;
  endfunction

endpackage

[sv/rgbd_stream_if.sv]
// ----------------------------------------------------------------------------
// RGB error diffusion dither stream interface
// Valid/ready channel carrying one item of the given payload type.
// ----------------------------------------------------------------------------
interface rgbd_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

[sv/rgbd_regs.sv]
// ----------------------------------------------------------------------------
// RGB error diffusion dither configuration registers
// APB-style register file for frame size and quantization levels.
// ----------------------------------------------------------------------------
module rgbd_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rgbd_pkg::CFG_AW-1:0] paddr,
  input  logic [rgbd_pkg::CFG_DW-1:0] pwdata,
  output logic [rgbd_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output rgbd_pkg::cfg_t             cfg_o
);

  logic [11:0] width_q;
  logic [15:0] height_q;
  logic [7:0]  levels_q;
  logic [7:0]  step_q;
  logic [1:0]  idx;
  logic        wr_en;

  assign idx    = paddr[rgbd_pkg::CFG_AW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rgbd_pkg::IMAGE_WIDTH_RESET;
      height_q <= rgbd_pkg::IMAGE_HEIGHT_RESET;
      levels_q <= rgbd_pkg::LEVELS_RESET;
      step_q   <= rgbd_pkg::step_of(rgbd_pkg::LEVELS_RESET);
    end else if (wr_en) begin
      unique case (idx)
        rgbd_pkg::REG_IMAGE_WIDTH:  width_q <= pwdata[11:0];
        rgbd_pkg::REG_IMAGE_HEIGHT: height_q <= pwdata[15:0];
        rgbd_pkg::REG_LEVELS: begin
          levels_q <= pwdata[7:0];
          step_q   <= rgbd_pkg::step_of(pwdata[7:0]);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      rgbd_pkg::REG_IMAGE_WIDTH:  prdata = {20'd0, width_q};
      rgbd_pkg::REG_IMAGE_HEIGHT: prdata = {16'd0, height_q};
      rgbd_pkg::REG_LEVELS:       prdata = {24'd0, levels_q};
      default:                    prdata = '0;
    endcase
  end

  assign cfg_o.image_width  = width_q;
  assign cfg_o.image_height = height_q;
  assign cfg_o.levels       = (levels_q == 8'd0) ? 8'd1 : levels_q;
  assign cfg_o.step         = step_q;

endmodule

[sv/rgbd_ctrl.sv]
// ----------------------------------------------------------------------------
// RGB error diffusion dither controller
// Sequences each item through read, diffusion, quantization and commit.
// ----------------------------------------------------------------------------
module rgbd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rgbd_pkg::dp_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ABOVE  = 2'd1;
  localparam logic [1:0] ST_LEFT   = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       commit;
  logic       accept;

  assign out_free   = !out_valid_q || out_ready_i;
  assign commit     = (state_q == ST_COMMIT) && out_free;
  assign in_ready_o = (state_q == ST_IDLE) || commit;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_ABOVE;
        end
      end
      ST_ABOVE: state_d = ST_LEFT;
      ST_LEFT:  state_d = ST_COMMIT;
      ST_COMMIT: begin
        if (out_free) begin
          state_d = accept ? ST_ABOVE : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cmd_o.load   = accept;
  assign cmd_o.above  = (state_q == ST_ABOVE);
  assign cmd_o.left   = (state_q == ST_LEFT);
  assign cmd_o.commit = commit;

endmodule

[sv/rgbd_datapath.sv]
// ----------------------------------------------------------------------------
// RGB error diffusion dither datapath
// Row error buffer, error window, diffusion, quantization and counters.
// ----------------------------------------------------------------------------
module rgbd_datapath #(
  parameter int MAX_LINE = rgbd_pkg::MAX_LINE_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rgbd_pkg::cfg_t        cfg_i,
  input  rgbd_pkg::dp_cmd_t     cmd_i,
  input  rgbd_pkg::pixel_in_t   pix_i,
  output rgbd_pkg::pixel_out_t  res_o
);

  localparam int CW = $clog2(MAX_LINE);
  localparam int AW = CW + 1;
  localparam int NCH = rgbd_pkg::NCH;

  logic [26:0] row_mem [MAX_LINE];

  logic [CW-1:0]        col_q;
  logic [15:0]          row_q;
  rgbd_pkg::rgb_t       pix_q;
  rgbd_pkg::rgb_err_t   rd_q;
  rgbd_pkg::rgb_err_t   win0_q, win1_q;
  rgbd_pkg::rgb_err_t   left_q;
  rgbd_pkg::rgb_t       v_q;
  rgbd_pkg::rgb_t       v4_q;
  logic [NCH-1:0][15:0] m_q;
  rgbd_pkg::pixel_out_t res_q;

  logic [AW-1:0]        w_eff;
  logic [15:0]          h_eff;
  logic                 last_col, last_row, first_col, above_ok, interior;
  logic [AW-1:0]        rd_addr;
  rgbd_pkg::rgb_t       pix_in;
  rgbd_pkg::rgb_err_t   a_l, a_c, a_r;
  rgbd_pkg::rgb_t       v3, v4, q_out, out_v;
  logic [NCH-1:0][15:0] m_d;
  rgbd_pkg::rgb_err_t   err_d;

  always_comb begin
    if (cfg_i.image_width < 12'(rgbd_pkg::MIN_WIDTH)) begin
      w_eff = AW'(rgbd_pkg::MIN_WIDTH);
    end else if (32'(cfg_i.image_width) > MAX_LINE) begin
      w_eff = AW'(MAX_LINE);
    end else begin
      w_eff = AW'(cfg_i.image_width);
    end
    if (cfg_i.image_height < 16'(rgbd_pkg::MIN_HEIGHT)) begin
      h_eff = 16'(rgbd_pkg::MIN_HEIGHT);
    end else begin
      h_eff = cfg_i.image_height;
    end
  end

  assign last_col  = ({1'b0, col_q} + AW'(1)) >= w_eff;
  assign last_row  = (17'(row_q) + 17'd1) >= 17'(h_eff);
  assign first_col = (col_q == '0);
  assign above_ok  = (row_q != 16'd0);
  assign interior  = !first_col && !last_col && !last_row;

  always_comb begin
    if (cmd_i.commit) begin
      rd_addr = last_col ? AW'(1) : ({1'b0, col_q} + AW'(2));
    end else begin
      rd_addr = {1'b0, col_q} + AW'(1);
    end
  end

  assign pix_in[0] = pix_i.red_in;
  assign pix_in[1] = pix_i.green_in;
  assign pix_in[2] = pix_i.blue_in;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      logic [7:0] v1, v2, n8;
      logic [16:0] n;
      logic [15:0] q;
      logic [9:0]  e;
      a_l[c] = first_col ? 9'd0 : win0_q[c];
      a_c[c] = first_col ? 9'd0 : win1_q[c];
      a_r[c] = (above_ok && !last_col) ? rd_q[c] : 9'd0;
      v1 = rgbd_pkg::add_clamp(pix_q[c],
             rgbd_pkg::diffuse($signed(a_l[c]), rgbd_pkg::W_ABOVE_LEFT));
      v2 = rgbd_pkg::add_clamp(v1,
             rgbd_pkg::diffuse($signed(a_c[c]), rgbd_pkg::W_ABOVE));
      v3[c] = rgbd_pkg::add_clamp(v2,
                rgbd_pkg::diffuse($signed(a_r[c]), rgbd_pkg::W_ABOVE_RIGHT));
      v4[c] = rgbd_pkg::add_clamp(v_q[c],
                rgbd_pkg::diffuse($signed(left_q[c]), rgbd_pkg::W_LEFT));
      m_d[c] = 16'(cfg_i.levels) * 16'(v4[c]) + 16'(rgbd_pkg::ROUND_BIAS);
      // Exact quotient by 255 for the operand range that can occur here.
      n = 17'(m_q[c]) + 17'(m_q[c][15:8]) + 17'd1;
      n8 = n[15:8];
      q = 16'(n8) * 16'(cfg_i.step);
      q_out[c] = q[7:0];
      e = {2'b00, v4_q[c]} - {2'b00, q[7:0]};
      out_v[c] = interior ? q_out[c] : v4_q[c];
      err_d[c] = interior ? e[8:0] : 9'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pix_q <= pix_in;
      if (rd_addr < AW'(MAX_LINE)) begin
        rd_q <= row_mem[rd_addr[CW-1:0]];
      end
    end
    if (cmd_i.commit) begin
      row_mem[col_q] <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.above) begin
      v_q <= v3;
    end
    if (cmd_i.left) begin
      v4_q <= v4;
      m_q  <= m_d;
    end
    if (cmd_i.commit) begin
      res_q.red_out   <= out_v[0];
      res_q.green_out <= out_v[1];
      res_q.blue_out  <= out_v[2];
      res_q.frame_end <= last_col && last_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      win0_q <= '0;
      win1_q <= '0;
      left_q <= '0;
    end else begin
      if (cmd_i.above) begin
        win0_q <= a_c;
        win1_q <= a_r;
      end
      if (cmd_i.commit) begin
        left_q <= err_d;
        if (last_col) begin
          col_q <= '0;
          row_q <= last_row ? 16'd0 : (row_q + 16'd1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
    end
  end

  assign res_o = res_q;

endmodule

[sv/rgb_error_diffusion_dither.sv]
// ----------------------------------------------------------------------------
// RGB error diffusion dither
// Streams RGB pixels in raster order and returns each one dithered with
// error diffusion weights of 1, 5, 3 and 7 sixteenths. A new item is
// accepted in the cycle its predecessor commits and not earlier. The row
// error memory is read at the acceptance edge, followed in order by the
// above-row diffusion, the left diffusion and multiply step, and the
// quantize and commit step. A stalled output holds the commit until the
// result register frees. The row error memory needs no clearing after
// reset.
// ----------------------------------------------------------------------------
module rgb_error_diffusion_dither #(
  parameter int MAX_LINE = rgbd_pkg::MAX_LINE_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  rgbd_stream_if.sink                 pixel_in_i,
  rgbd_stream_if.source               pixel_out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rgbd_pkg::CFG_AW-1:0] paddr,
  input  logic [rgbd_pkg::CFG_DW-1:0] pwdata,
  output logic [rgbd_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);

  rgbd_pkg::cfg_t       cfg;
  rgbd_pkg::dp_cmd_t    cmd;
  rgbd_pkg::pixel_in_t  pix;
  rgbd_pkg::pixel_out_t res;
  logic                 in_ready;
  logic                 out_valid;

  assign pix = pixel_in_i.data;

  rgbd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rgbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pixel_in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (pixel_out_o.ready),
    .cmd_o       (cmd)
  );

  rgbd_datapath #(
    .MAX_LINE (MAX_LINE)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .cmd_i  (cmd),
    .pix_i  (pix),
    .res_o  (res)
  );

  assign pixel_in_i.ready  = in_ready;
  assign pixel_out_o.valid = out_valid;
  assign pixel_out_o.data  = res;

endmodule

[sv/rgbd_chk.sv]
// ----------------------------------------------------------------------------
// RGB error diffusion dither port checker
// Checks item flow and handshake properties seen at the top level ports.
// ----------------------------------------------------------------------------
`include "rgb_error_diffusion_dither_defines.svh"

module rgbd_chk (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input rgbd_pkg::pixel_out_t out_data_i
);

  logic [1:0] pend_q, pend_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `RGBD_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i), "stalled result changed")
  `RGBD_ASSERT_NEXT(a_in_gap, in_acc, !in_ready_i, "item accepted in back to back cycles")
  `RGBD_ASSERT_SAME(a_no_phantom, out_valid_i, pend_q != 2'd0, "result without an accepted item")
  `RGBD_ASSERT_SAME(a_idle_ready, pend_q == 2'd0, in_ready_i, "empty block not ready")
  `RGBD_ASSERT_SAME(a_pend_bound, 1'b1, pend_q != 2'd3, "too many items in flight")

endmodule

bind rgb_error_diffusion_dither rgbd_chk u_rgbd_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pixel_in_i.valid),
  .in_ready_i  (pixel_in_i.ready),
  .out_valid_i (pixel_out_o.valid),
  .out_ready_i (pixel_out_o.ready),
  .out_data_i  (pixel_out_o.data)
);
